// File: hw/rtl/utf8_terminal_safe_escaper_defines.svh
// assertion macros for the utf8 terminal safe escaper checker
`ifndef UTF8_TERMINAL_SAFE_ESCAPER_DEFINES_SVH
`define UTF8_TERMINAL_SAFE_ESCAPER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define UTE_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ute assertion failed");

// next-cycle implication, disabled in reset
`define UTE_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ute assertion failed");

`endif

// File: hw/rtl/ute_pkg.sv
// shared types, constants and utf-8 classification functions
package ute_pkg;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_WAIT  = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  localparam logic [127:0] HEX_CHARS = "0123456789ABCDEF";
  localparam logic [7:0]   BACKSLASH = 8'h5c;
  localparam logic [7:0]   LOWER_X   = 8'h78;

  typedef struct packed {
    logic [7:0] ch;
    logic       esc;
    logic       run_last;
    logic       text_end;
  } op_t;

  typedef struct packed {
    logic [1:0] st;
    logic [2:0] len;
    logic       safe;
  } cls_t;

  function automatic logic is_cont(logic [7:0] b);
    return (b >= 8'h80) && (b <= 8'hbf);
  endfunction

  function automatic logic cp_safe(logic [20:0] cp);
    logic bidi;
    bidi = (cp == 21'h00061c) || (cp == 21'h00200e) || (cp == 21'h00200f) ||
           ((cp >= 21'h00202a) && (cp <= 21'h00202e)) ||
           ((cp >= 21'h002066) && (cp <= 21'h002069));
    return (cp >= 21'h000020) && !((cp >= 21'h00007f) && (cp <= 21'h00009f)) &&
           (cp != 21'h00005c) && (cp != 21'h002028) && (cp != 21'h002029) &&
           (cp != 21'h00feff) && !bidi;
  endfunction

  function automatic logic [31:0] rot_win(logic [31:0] w, logic [1:0] s);
    logic [63:0] d;
    d = {w, w} >> {s, 3'b000};
    return d[31:0];
  endfunction

  // window byte 0 is the lead byte, avail counts the bytes present
  function automatic cls_t classify(logic [31:0] w, logic [2:0] avail);
    logic [7:0]  f;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [2:0]  need;
    logic        ok1;
    logic        bad;
    logic [20:0] cp;
    cls_t        r;
    f  = w[7:0];
    b1 = w[15:8];
    b2 = w[23:16];
    b3 = w[31:24];
    if (f <= 8'h7f) begin
      need = 3'd1;
    end else if ((f >= 8'hc2) && (f <= 8'hdf)) begin
      need = 3'd2;
    end else if ((f >= 8'he0) && (f <= 8'hef)) begin
      need = 3'd3;
    end else if ((f >= 8'hf0) && (f <= 8'hf4)) begin
      need = 3'd4;
    end else begin
      need = 3'd0;
    end
    case (f)
      8'he0:   ok1 = (b1 >= 8'ha0) && (b1 <= 8'hbf);
      8'hed:   ok1 = (b1 >= 8'h80) && (b1 <= 8'h9f);
      8'hf0:   ok1 = (b1 >= 8'h90) && (b1 <= 8'hbf);
      8'hf4:   ok1 = (b1 >= 8'h80) && (b1 <= 8'h8f);
      default: ok1 = is_cont(b1);
    endcase
    bad = (need == 3'd0) ||
          ((need > 3'd1) && (avail > 3'd1) && !ok1) ||
          ((need > 3'd2) && (avail > 3'd2) && !is_cont(b2)) ||
          ((need > 3'd3) && (avail > 3'd3) && !is_cont(b3));
    case (need)
      3'd2:    cp = {10'd0, f[4:0], b1[5:0]};
      3'd3:    cp = {5'd0, f[3:0], b1[5:0], b2[5:0]};
      3'd4:    cp = {f[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: cp = {13'd0, f};
    endcase
    if (bad) begin
      r.st = ST_BAD;
    end else if (avail < need) begin
      r.st = ST_WAIT;
    end else begin
      r.st = ST_VALID;
    end
    r.len  = need;
    r.safe = cp_safe(cp);
    return r;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    return HEX_CHARS[{4'hf - n, 3'b000} +: 8];
  endfunction

endpackage

// File: hw/rtl/utf8_terminal_safe_escaper.sv
// top level of the utf-8 validator and terminal-safe escaper
//
//   channel | handshake              | payload
//   input   | in_valid / in_ready    | in_byte, in_last
//   output  | out_valid / out_ready  | out_char, is_escape, run_last, text_end
//
// the front takes one byte while idle, then takes no other until it has issued one
// op per byte it releases (up to four), or found that the byte only extends a pending sequence
// the back sends one character a cycle unless stalled: one per copied byte, four per escaped byte
// a four-entry op queue sits between front and back; either side stalls on its own
// synchronous reset empties the queue and clears the pending byte count
module utf8_terminal_safe_escaper (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       is_escape,
  output logic       run_last,
  output logic       text_end
);
  import ute_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_empty;
  op_t  push_op;
  op_t  head_op;

  ute_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_op     (push_op)
  );

  ute_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .head_op (head_op),
    .empty   (q_empty)
  );

  ute_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_op   (head_op),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .is_escape (is_escape),
    .run_last  (run_last),
    .text_end  (text_end)
  );

endmodule

// File: hw/rtl/ute_front.sv
// front end: takes bytes, holds pending bytes, classifies and issues byte ops
module ute_front (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic        q_full,
  output logic        q_push,
  output ute_pkg::op_t q_op
);
  import ute_pkg::*;

  logic        busy;
  logic        busy_next;
  logic [31:0] win;
  logic [31:0] win_next;
  logic [2:0]  cnt;
  logic [2:0]  cnt_next;
  logic [2:0]  pos;
  logic [2:0]  pos_next;
  logic [1:0]  rem;
  logic [1:0]  rem_next;
  logic        run_esc;
  logic        run_esc_next;
  logic        last;
  logic        last_next;

  logic [31:0] cur_w;
  logic [31:0] la_w;
  logic [2:0]  pos_n;
  cls_t        cls;
  cls_t        la;
  logic [1:0]  st_eff;
  logic        wait_now;
  logic [2:0]  len_m1;
  logic [1:0]  rem_after;
  logic        op_esc;
  logic        op_last;

  assign in_ready = !busy;

  assign pos_n  = pos + 3'd1;
  assign cur_w  = rot_win(win, pos[1:0]);
  assign la_w   = rot_win(win, pos_n[1:0]);
  assign cls    = classify(cur_w, cnt - pos);
  assign la     = classify(la_w, cnt - pos_n);
  assign st_eff = ((cls.st == ST_WAIT) && last) ? ST_BAD : cls.st;
  assign len_m1 = cls.len - 3'd1;

  assign wait_now = busy && (rem == 2'd0) && (st_eff == ST_WAIT);

  always_comb begin
    if (rem != 2'd0) begin
      rem_after = rem - 2'd1;
      op_esc    = run_esc;
    end else if (st_eff == ST_VALID) begin
      rem_after = len_m1[1:0];
      op_esc    = !cls.safe;
    end else begin
      rem_after = 2'd0;
      op_esc    = 1'b1;
    end
  end

  assign op_last = (rem_after == 2'd0) &&
                   ((pos_n == cnt) || (!last && (la.st == ST_WAIT)));

  assign q_push      = busy && !wait_now && !q_full;
  assign q_op.ch       = cur_w[7:0];
  assign q_op.esc      = op_esc;
  assign q_op.run_last = op_last;
  assign q_op.text_end = op_last && last;

  always_comb begin
    busy_next    = busy;
    win_next     = win;
    cnt_next     = cnt;
    pos_next     = pos;
    rem_next     = rem;
    run_esc_next = run_esc;
    last_next    = last;
    if (!busy) begin
      if (in_valid) begin
        win_next[{cnt[1:0], 3'b000} +: 8] = in_byte;
        cnt_next  = cnt + 3'd1;
        last_next = in_last;
        pos_next  = 3'd0;
        rem_next  = 2'd0;
        busy_next = 1'b1;
      end
    end else if (wait_now) begin
      win_next  = cur_w;
      cnt_next  = cnt - pos;
      busy_next = 1'b0;
    end else if (!q_full) begin
      pos_next = pos_n;
      rem_next = rem_after;
      if (rem == 2'd0) begin
        run_esc_next = op_esc;
      end
      if (op_last) begin
        win_next  = la_w;
        cnt_next  = cnt - pos_n;
        busy_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 3'd0;
      pos  <= 3'd0;
      rem  <= 2'd0;
    end else begin
      busy <= busy_next;
      cnt  <= cnt_next;
      pos  <= pos_next;
      rem  <= rem_next;
    end
    win     <= win_next;
    run_esc <= run_esc_next;
    last    <= last_next;
  end

endmodule

// File: hw/rtl/ute_fifo.sv
// short queue of byte ops between front and back
module ute_fifo (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  ute_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output ute_pkg::op_t head_op,
  output logic         empty
);
  import ute_pkg::*;

  op_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == Q_CW'(Q_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head_op = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + Q_CW'(1);
        2'b01:   count <= count - Q_CW'(1);
        default: count <= count;
      endcase
    end
    if (do_push) begin
      mem[wr_ptr] <= push_op;
    end
  end

endmodule

// File: hw/rtl/ute_back.sv
// back end: expands byte ops into output characters through an output register
module ute_back (
  input  logic         clk,
  input  logic         rst,
  input  ute_pkg::op_t head_op,
  input  logic         q_empty,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   out_char,
  output logic         is_escape,
  output logic         run_last,
  output logic         text_end
);
  import ute_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       op_done;
  logic [7:0] ch;

  assign load    = !q_empty && (!out_valid || out_ready);
  assign op_done = !head_op.esc || (idx == 2'd3);
  assign q_pop   = load && op_done;

  always_comb begin
    if (!head_op.esc) begin
      ch = head_op.ch;
    end else begin
      case (idx)
        2'd0:    ch = BACKSLASH;
        2'd1:    ch = LOWER_X;
        2'd2:    ch = hex_char(head_op.ch[7:4]);
        default: ch = hex_char(head_op.ch[3:0]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= op_done ? 2'd0 : idx + 2'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      out_char  <= ch;
      is_escape <= head_op.esc;
      run_last  <= op_done && head_op.run_last;
      text_end  <= op_done && head_op.text_end;
    end
  end

endmodule

// File: hw/rtl/ute_checker.sv
// port-level checker for the escaper and its bind
`include "utf8_terminal_safe_escaper_defines.svh"

module ute_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       is_escape,
  input logic       run_last,
  input logic       text_end
);

  // a stalled transaction holds its character
  `UTE_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_char))

  // a backslash is never copied through
  `UTE_ASSERT_IMP(a_no_raw_bslash, clk, rst, out_valid && !is_escape, out_char != 8'h5c)

  // an escape never ends on its leading backslash
  `UTE_ASSERT_IMP(a_esc_head, clk, rst, out_valid && is_escape && out_char == 8'h5c, !run_last && !text_end)

  // end of text is always the end of a byte's run
  `UTE_ASSERT_IMP(a_end_run, clk, rst, out_valid && text_end, run_last)

endmodule

bind utf8_terminal_safe_escaper ute_checker u_chk (.*);

// File: tb/sv/testbench.sv
// self-checking testbench for the utf-8 validator and terminal-safe escaper
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT     = 22;
  localparam int CHOKE_CYCLES = 80;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic [7:0] ESC_LEAD = 8'h5c;
  localparam logic [7:0] ESC_X    = 8'h78;
  localparam logic [7:0] DIGIT_0  = 8'h30;
  localparam logic [7:0] LETTER_A = 8'h41;

  typedef enum logic [1:0] {SEQ_OK, SEQ_SHORT, SEQ_BAD} seq_st_t;

  typedef struct packed {
    logic [7:0] val;
    logic       fin;
  } text_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       esc;
    logic       run_last;
    logic       text_end;
  } char_rec_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       is_escape;
  logic       run_last;
  logic       text_end;

  text_byte_t tx_q[$];
  char_rec_t  exp_chars[$];
  logic [7:0] pend_bytes [0:2];
  int         pend_cnt = 0;
  logic [7:0] win [0:3];
  logic       calm = 1'b0;
  logic       choke_go = 1'b0;
  logic       choke_done = 1'b0;
  int         choke_left = 0;
  int         errors = 0;
  int         cycles = 0;

  utf8_terminal_safe_escaper u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .is_escape (is_escape),
    .run_last  (run_last),
    .text_end  (text_end)
  );

  always #5 clk = ~clk;

  function automatic logic term_safe(logic [20:0] cp);
    logic bidi;
    bidi = (cp == 21'h061c) || (cp == 21'h200e) || (cp == 21'h200f) ||
           (cp >= 21'h202a && cp <= 21'h202e) || (cp >= 21'h2066 && cp <= 21'h2069);
    return (cp >= 21'h20) && !(cp >= 21'h7f && cp <= 21'h9f) && (cp != 21'h5c) &&
           (cp != 21'h2028) && (cp != 21'h2029) && (cp != 21'hfeff) && !bidi;
  endfunction

  function automatic seq_st_t scan_seq(int at, int avail, output int len,
                                       output logic [20:0] cp);
    logic [7:0] f;
    logic [7:0] b;
    logic       ok;
    int         need;
    int         i;
    f = win[at];
    len = 1;
    cp = {13'd0, f};
    if (f <= 8'h7f) return SEQ_OK;
    if (f >= 8'hc2 && f <= 8'hdf) need = 2;
    else if (f >= 8'he0 && f <= 8'hef) need = 3;
    else if (f >= 8'hf0 && f <= 8'hf4) need = 4;
    else return SEQ_BAD;
    for (i = 1; i < need && i < avail; i++) begin
      b = win[at + i];
      if (i == 1 && f == 8'he0) ok = (b >= 8'ha0 && b <= 8'hbf);
      else if (i == 1 && f == 8'hed) ok = (b >= 8'h80 && b <= 8'h9f);
      else if (i == 1 && f == 8'hf0) ok = (b >= 8'h90 && b <= 8'hbf);
      else if (i == 1 && f == 8'hf4) ok = (b >= 8'h80 && b <= 8'h8f);
      else ok = (b >= 8'h80 && b <= 8'hbf);
      if (!ok) return SEQ_BAD;
    end
    if (avail < need) return SEQ_SHORT;
    if (need == 2)
      cp = {10'd0, win[at][4:0], win[at+1][5:0]};
    else if (need == 3)
      cp = {5'd0, win[at][3:0], win[at+1][5:0], win[at+2][5:0]};
    else
      cp = {win[at][2:0], win[at+1][5:0], win[at+2][5:0], win[at+3][5:0]};
    len = need;
    return SEQ_OK;
  endfunction

  function automatic logic [7:0] nibble_char(logic [3:0] n);
    return (n < 4'd10) ? DIGIT_0 + {4'd0, n} : LETTER_A + {4'd0, n} - 8'd10;
  endfunction

  function automatic void push_char(logic [7:0] ch, logic esc);
    char_rec_t r;
    r.ch = ch;
    r.esc = esc;
    r.run_last = 1'b0;
    r.text_end = 1'b0;
    exp_chars.insert(exp_chars.size(), r);
  endfunction

  function automatic void push_escape(logic [7:0] b);
    push_char(ESC_LEAD, 1'b1);
    push_char(ESC_X, 1'b1);
    push_char(nibble_char(b[7:4]), 1'b1);
    push_char(nibble_char(b[3:0]), 1'b1);
  endfunction

  // expected output characters for one accepted input byte
  function automatic void escape_step(text_byte_t t);
    int          cnt;
    int          pos;
    int          len;
    int          n;
    int          i;
    logic [20:0] cp;
    seq_st_t     st;
    cnt = pend_cnt;
    for (i = 0; i < cnt; i++) win[i] = pend_bytes[i];
    win[cnt] = t.val;
    cnt++;
    pos = 0;
    n = 0;
    while (pos < cnt) begin
      st = scan_seq(pos, cnt - pos, len, cp);
      if (st == SEQ_SHORT && t.fin) st = SEQ_BAD;
      if (st == SEQ_SHORT) break;
      if (st == SEQ_BAD) begin
        push_escape(win[pos]);
        n += 4;
        pos++;
      end else begin
        for (i = 0; i < len; i++) begin
          if (term_safe(cp)) begin
            push_char(win[pos + i], 1'b0);
            n++;
          end else begin
            push_escape(win[pos + i]);
            n += 4;
          end
        end
        pos += len;
      end
    end
    pend_cnt = cnt - pos;
    for (i = 0; i < pend_cnt; i++) pend_bytes[i] = win[pos + i];
    if (n > 0) begin
      exp_chars[exp_chars.size() - 1].run_last = 1'b1;
      exp_chars[exp_chars.size() - 1].text_end = t.fin;
    end
  endfunction

  function automatic void put(logic [7:0] b, logic fin = 1'b0);
    text_byte_t t;
    t.val = b;
    t.fin = fin;
    tx_q.insert(tx_q.size(), t);
  endfunction

  function automatic int put_cp(logic [20:0] cp);
    if (cp < 21'h80) begin
      put(cp[7:0]);
      return 1;
    end
    if (cp < 21'h800) begin
      put({3'b110, cp[10:6]});
      put({2'b10, cp[5:0]});
      return 2;
    end
    if (cp < 21'h10000) begin
      put({4'b1110, cp[15:12]});
      put({2'b10, cp[11:6]});
      put({2'b10, cp[5:0]});
      return 3;
    end
    put({5'b11110, cp[20:18]});
    put({2'b10, cp[17:12]});
    put({2'b10, cp[11:6]});
    put({2'b10, cp[5:0]});
    return 4;
  endfunction

  function automatic logic [20:0] rand_wide_cp();
    logic [20:0] cp;
    case ($urandom_range(0, 2))
      0: cp = 21'($urandom_range(32'h80, 32'h7ff));
      1: begin
        cp = 21'($urandom_range(32'h800, 32'hffff));
        if (cp >= 21'hd800 && cp <= 21'hdfff) cp = cp ^ 21'h1000;
      end
      default: cp = 21'($urandom_range(32'h10000, 32'h10ffff));
    endcase
    return cp;
  endfunction

  function automatic logic [20:0] risky_cp();
    case ($urandom_range(0, 14))
      0:  return 21'h2028;
      1:  return 21'h2029;
      2:  return 21'hfeff;
      3:  return 21'h061c;
      4:  return 21'h200e;
      5:  return 21'h200f;
      6:  return 21'h5c;
      7:  return 21'h7f;
      8:  return 21'h85;
      9:  return 21'h1f;
      10: return 21'h202a + 21'($urandom_range(0, 4));
      11: return 21'h2066 + 21'($urandom_range(0, 3));
      12: return 21'h9f;
      13: return 21'ha0;
      default: return 21'h20;
    endcase
  endfunction

  function automatic int rand_char();
    int          k;
    int          n;
    logic [20:0] cp;
    k = $urandom_range(0, 99);
    if (k < 30) begin
      cp = 21'($urandom_range(0, 127));
      return put_cp(cp);
    end
    if (k < 62) return put_cp(rand_wide_cp());
    if (k < 74) return put_cp(risky_cp());
    if (k < 84) begin
      put(8'($urandom_range(0, 255)));
      return 1;
    end
    if (k < 92) begin
      n = put_cp(rand_wide_cp());
      void'(tx_q.pop_back());
      return n - 1;
    end
    case ($urandom_range(0, 3))
      0: put(8'he0);
      1: put(8'hed);
      2: put(8'hf0);
      default: put(8'hf4);
    endcase
    put(8'($urandom_range(8'h80, 8'hbf)));
    put(8'($urandom_range(8'h80, 8'hbf)));
    return 3;
  endfunction

  function automatic int add_text();
    int cnt;
    int len;
    int i;
    cnt = 0;
    len = $urandom_range(1, 10);
    for (i = 0; i < len; i++) cnt += rand_char();
    tx_q[tx_q.size() - 1].fin = 1'b1;
    return cnt;
  endfunction

  // sender
  always @(posedge clk) begin
    text_byte_t t;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        t.val = in_byte;
        t.fin = in_last;
        escape_step(t);
      end
      if (!in_valid || in_ready) begin
        if (tx_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          t = tx_q.pop_front();
          in_byte  <= t.val;
          in_last  <= t.fin;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (choke_go && !choke_done) begin
      choke_done <= 1'b1;
      choke_left <= CHOKE_CYCLES;
      out_ready  <= 1'b0;
    end else if (choke_left > 0) begin
      choke_left <= choke_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // output monitor
  always @(posedge clk) begin
    char_rec_t want;
    if (!rst && out_valid && out_ready) begin
      if (exp_chars.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual char %0h",
                 $time, out_char);
        errors++;
      end else begin
        want = exp_chars.pop_front();
        check_field("out_char", want.ch, out_char);
        check_field("is_escape", want.esc, is_escape);
        check_field("run_last", want.run_last, run_last);
        check_field("text_end", want.text_end, text_end);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic wait_idle();
    while (tx_q.size() != 0 || in_valid || exp_chars.size() != 0) @(negedge clk);
  endtask

  initial begin
    int added;
    // directed text: extremes, unsafe points, invalid and truncated forms
    put(8'h41);
    put(8'h00);
    put(8'h7f);
    put(8'h5c);
    put(8'hff);
    put(8'hc0);
    put(8'h80);
    put(8'hc2); put(8'h85);
    put(8'he2); put(8'h80); put(8'hae);
    put(8'hef); put(8'hbb); put(8'hbf);
    put(8'hf4); put(8'h8f); put(8'hbf); put(8'hbf);
    put(8'hf4); put(8'h90);
    put(8'he0); put(8'h80);
    put(8'hed); put(8'ha0);
    put(8'hf0); put(8'h9f); put(8'h98, 1'b1);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    wait_idle();
    // long receiver hold-off while the sender keeps offering
    added = 0;
    while (added < 65) added += add_text();
    choke_go = 1'b1;
    wait_idle();
    // stretch without idling on either side, then random idling again
    calm = 1'b1;
    added = 0;
    while (added < 50) added += add_text();
    while (tx_q.size() != 0) @(negedge clk);
    calm = 1'b0;
    added = 0;
    while (added < 55) added += add_text();
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
